// ----- src/i2cm_pkg.sv -----
// Shared types and constants for the I2C master byte controller.
// Holds the channel payload structs, the classified command item and command codes.
// No dependencies.
`default_nettype none

package i2cm_pkg;

  localparam int DATA_BITS = 8;
  localparam logic [7:0] MSB_MASK = 8'h80;
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_NONE  = 2'd0;
  localparam cmd_t CMD_WRITE = 2'd1;
  localparam cmd_t CMD_READ  = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic       start_req;
    logic       stop_req;
    logic [7:0] tx_byte;
    logic       ack_to_send;
    logic       scl_in;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       ready_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_received;
    logic       arb_lost;
  } out_item_t;

  typedef struct packed {
    cmd_t       cmd;
    logic       start_req;
    logic       stop_req;
    logic [7:0] tx_byte;
    logic       ack_to_send;
    logic       scl_in;
    logic       sda_in;
  } cmd_item_t;

  typedef struct packed {
    logic      valid;
    cmd_item_t item;
  } queue_head_t;

endpackage

`default_nettype wire

// ----- src/i2cm_front.sv -----
// Front end: accepts input transactions, decodes the command code and queues them.
// Depends on i2cm_pkg.
`default_nettype none

module i2cm_front import i2cm_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_item,
  output queue_head_t      head,
  input  wire logic        head_pop
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  cmd_item_t           mem_r [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]     cnt_r, cnt_nxt;
  cmd_item_t           cls;
  logic                push;
  logic                pop;

  always_comb begin
    cls.cmd = CMD_NONE;
    case (in_item.func)
      CMD_WRITE: cls.cmd = CMD_WRITE;
      CMD_READ: cls.cmd = CMD_READ;
      default: cls.cmd = CMD_NONE;
    endcase
    cls.start_req   = in_item.start_req;
    cls.stop_req    = in_item.stop_req;
    cls.tx_byte     = in_item.tx_byte;
    cls.ack_to_send = in_item.ack_to_send;
    cls.scl_in      = in_item.scl_in;
    cls.sda_in      = in_item.sda_in;
  end

  assign in_ready   = (cnt_r != CntW'(QueueDepth));
  assign push       = in_valid && in_ready;
  assign pop        = head_pop && (cnt_r != '0);
  assign head.valid = (cnt_r != '0);
  assign head.item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

`default_nettype wire

// ----- src/i2cm_engine.sv -----
// Back end: the bus sequencer that advances one tick per queued transaction.
// Holds the half-period register and the result register. Depends on i2cm_pkg.
`default_nettype none

module i2cm_engine import i2cm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,
  input  wire queue_head_t head,
  output logic             head_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_item
);

  localparam logic [3:0] PH_IDLE        = 4'd0;
  localparam logic [3:0] PH_START_SETUP = 4'd1;
  localparam logic [3:0] PH_START_WAIT  = 4'd2;
  localparam logic [3:0] PH_START_HOLD  = 4'd3;
  localparam logic [3:0] PH_BIT_SETUP   = 4'd4;
  localparam logic [3:0] PH_BIT_WAIT    = 4'd5;
  localparam logic [3:0] PH_BIT_HOLD    = 4'd6;
  localparam logic [3:0] PH_STOP_SETUP  = 4'd7;
  localparam logic [3:0] PH_STOP_WAIT   = 4'd8;
  localparam logic [3:0] PH_STOP_HOLD   = 4'd9;

  localparam int FL_STOP = 0;
  localparam int FL_READ = 1;
  localparam int FL_ACK  = 2;
  localparam int FL_ARB  = 3;
  localparam int DRV_SCL = 0;
  localparam int DRV_SDA = 1;
  localparam logic [3:0] NBITS = 4'(DATA_BITS);

  logic [15:0] hpt_r;
  logic [3:0]  phase_r, phase_nxt;
  logic [3:0]  bc_r, bc_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [15:0] dly_r, dly_nxt;
  logic        bus_r, bus_nxt;
  logic [3:0]  flags_r, flags_nxt;
  logic [1:0]  drv_r, drv_nxt;
  logic [7:0]  rx_r, rx_nxt;
  logic        ack_r, ack_nxt;
  logic        done;
  logic        step;
  logic        out_valid_r;
  out_item_t   out_item_r;

  function automatic logic bit_released(input logic [3:0] fl, input logic [7:0] sh,
                                        input logic [3:0] bc);
    logic rd;
    rd = fl[FL_READ];
    if (bc < NBITS) begin
      bit_released = rd ? 1'b1 : ((sh & MSB_MASK) != 8'h00);
    end else begin
      bit_released = rd ? fl[FL_ACK] : 1'b1;
    end
  endfunction

  assign cfg_ready = 1'b1;
  assign head_pop  = head.valid && (!out_valid_r || out_ready);
  assign step      = head_pop;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    logic dd;
    logic rd;
    logic mw;
    cmd_item_t it;
    it        = head.item;
    rd        = flags_r[FL_READ];
    dd        = (dly_r >= hpt_r);
    phase_nxt = phase_r;
    bc_nxt    = bc_r;
    shift_nxt = shift_r;
    dly_nxt   = dd ? dly_r : dly_r + 16'd1;
    bus_nxt   = bus_r;
    flags_nxt = flags_r;
    drv_nxt   = drv_r;
    rx_nxt    = rx_r;
    ack_nxt   = ack_r;
    done      = 1'b0;
    mw        = rd ? (bc_r >= NBITS) : (bc_r < NBITS);
    case (phase_r)
      PH_START_SETUP: begin
        if (dd) begin
          drv_nxt[DRV_SCL] = 1'b0;
          phase_nxt = PH_START_WAIT;
          dly_nxt = '0;
        end
      end
      PH_START_WAIT: begin
        dly_nxt = dly_r;
        if (it.scl_in) begin
          if (!it.sda_in) begin
            flags_nxt[FL_ARB] = 1'b1;
          end
          drv_nxt[DRV_SDA] = 1'b1;
          phase_nxt = PH_START_HOLD;
          dly_nxt = '0;
        end
      end
      PH_START_HOLD: begin
        if (dd) begin
          drv_nxt[DRV_SCL] = 1'b1;
          bus_nxt = 1'b1;
          phase_nxt = PH_BIT_SETUP;
          dly_nxt = '0;
          drv_nxt[DRV_SDA] = !bit_released(flags_r, shift_r, bc_r);
        end
      end
      PH_BIT_SETUP: begin
        if (dd) begin
          drv_nxt[DRV_SCL] = 1'b0;
          phase_nxt = PH_BIT_WAIT;
          dly_nxt = '0;
        end
      end
      PH_BIT_WAIT: begin
        dly_nxt = dly_r;
        if (it.scl_in) begin
          if (mw) begin
            if (bit_released(flags_r, shift_r, bc_r) && !it.sda_in) begin
              flags_nxt[FL_ARB] = 1'b1;
            end
          end else if (bc_r < NBITS) begin
            shift_nxt = {shift_r[6:0], it.sda_in};
          end else begin
            ack_nxt = it.sda_in;
          end
          phase_nxt = PH_BIT_HOLD;
          dly_nxt = '0;
        end
      end
      PH_BIT_HOLD: begin
        if (dd) begin
          drv_nxt[DRV_SCL] = 1'b1;
          if (!rd && bc_r < NBITS) begin
            shift_nxt = {shift_r[6:0], 1'b0};
          end
          bc_nxt = bc_r + 4'd1;
          if (bc_nxt <= NBITS) begin
            phase_nxt = PH_BIT_SETUP;
            dly_nxt = '0;
            drv_nxt[DRV_SDA] = !bit_released(flags_r, shift_nxt, bc_nxt);
          end else if (flags_r[FL_STOP]) begin
            drv_nxt[DRV_SDA] = 1'b1;
            phase_nxt = PH_STOP_SETUP;
            dly_nxt = '0;
          end else begin
            done = 1'b1;
          end
        end
      end
      PH_STOP_SETUP: begin
        if (dd) begin
          drv_nxt[DRV_SCL] = 1'b0;
          phase_nxt = PH_STOP_WAIT;
          dly_nxt = '0;
        end
      end
      PH_STOP_WAIT: begin
        dly_nxt = dly_r;
        if (it.scl_in) begin
          drv_nxt[DRV_SDA] = 1'b0;
          phase_nxt = PH_STOP_HOLD;
          dly_nxt = '0;
        end
      end
      PH_STOP_HOLD: begin
        if (dly_r == 16'd0 && !it.sda_in) begin
          flags_nxt[FL_ARB] = 1'b1;
        end
        if (dd) begin
          bus_nxt = 1'b0;
          done = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        dly_nxt = dly_r;
        if (it.cmd == CMD_WRITE || it.cmd == CMD_READ) begin
          flags_nxt = '0;
          flags_nxt[FL_STOP] = it.stop_req;
          flags_nxt[FL_READ] = (it.cmd == CMD_READ);
          flags_nxt[FL_ACK]  = it.ack_to_send;
          shift_nxt = (it.cmd == CMD_WRITE) ? it.tx_byte : 8'h00;
          bc_nxt = '0;
          dly_nxt = '0;
          if (it.start_req) begin
            drv_nxt[DRV_SDA] = 1'b0;
            if (bus_r) begin
              phase_nxt = PH_START_SETUP;
            end else begin
              drv_nxt[DRV_SCL] = 1'b0;
              phase_nxt = PH_START_WAIT;
            end
          end else begin
            phase_nxt = PH_BIT_SETUP;
            drv_nxt[DRV_SDA] = !bit_released(flags_nxt, shift_nxt, bc_nxt);
          end
        end
      end
    endcase
    if (done) begin
      if (rd) begin
        rx_nxt = shift_nxt;
      end
      phase_nxt = PH_IDLE;
      dly_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hpt_r       <= '0;
      phase_r     <= PH_IDLE;
      bc_r        <= '0;
      shift_r     <= '0;
      dly_r       <= '0;
      bus_r       <= 1'b0;
      flags_r     <= '0;
      drv_r       <= '0;
      rx_r        <= '0;
      ack_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        hpt_r <= cfg_data;
      end
      if (step) begin
        phase_r <= phase_nxt;
        bc_r    <= bc_nxt;
        shift_r <= shift_nxt;
        dly_r   <= dly_nxt;
        bus_r   <= bus_nxt;
        flags_r <= flags_nxt;
        drv_r   <= drv_nxt;
        rx_r    <= rx_nxt;
        ack_r   <= ack_nxt;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item_r.scl_drive_low <= drv_nxt[DRV_SCL];
      out_item_r.sda_drive_low <= drv_nxt[DRV_SDA];
      out_item_r.ready_res     <= (phase_nxt == PH_IDLE);
      out_item_r.done_res      <= done;
      out_item_r.rx_byte       <= rx_nxt;
      out_item_r.ack_received  <= ack_nxt;
      out_item_r.arb_lost      <= flags_nxt[FL_ARB];
    end
  end

endmodule

`default_nettype wire

// ----- src/i2c_master_byte_controller.sv -----
// I2C master byte controller: one bus tick per input transaction, one result per tick.
// Each input transaction carries the command fields and the sampled SCL and SDA levels.
// The front end decodes and queues transactions; the engine runs the bus sequencer.
// The configuration channel writes the half-period tick count and is always ready;
// write it only while no transaction is in flight (the block does not enforce this).
// Every accepted input transaction yields exactly one result transaction, in order.
// With the queue empty, an accepted input is queued and then stepped into the result
// register; throughput is one transaction per cycle while the receiver takes results.
// Reset puts the sequencer in idle with both lines released and the half period at zero.
// When the receiver stalls, the result register holds and the queue fills; once the
// queue is full, in_ready falls until results are taken again.
// Depends on i2cm_pkg, i2cm_front and i2cm_engine.
`default_nettype none

module i2c_master_byte_controller import i2cm_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_item,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  queue_head_t head;
  logic        head_pop;

  i2cm_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .head     (head),
    .head_pop (head_pop)
  );

  i2cm_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .head      (head),
    .head_pop  (head_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ----- tb/i2c_master_byte_controller_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the I2C master byte controller: a table of directed commands,
// then random bus ticks on a wired-AND bus model, each result checked against a tick model.
// Depends on i2cm_pkg and the i2c_master_byte_controller RTL.
module i2c_master_byte_controller_test;
  import i2cm_pkg::*;

  localparam cmd_t CMD_UNUSED = 2'd3;
  localparam logic [3:0] BYTE_BITS = 4'(DATA_BITS);
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 8;
  localparam int ROW_TICK_CAP = 500;
  localparam int MAX_WAIT = 10;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RESTART_SETUP,
    S_START_WAIT,
    S_START_HOLD,
    S_BIT_SETUP,
    S_BIT_WAIT,
    S_BIT_HOLD,
    S_STOP_SETUP,
    S_STOP_WAIT,
    S_STOP_HOLD
  } seq_phase_e;

  typedef struct {
    in_item_t  cmd;
    logic      slave_sda;
    bit        typed;
    out_item_t want;
  } cmd_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  // Model state of the byte engine.
  seq_phase_e  m_phase;
  logic [3:0]  m_bits;
  logic [7:0]  m_shift;
  logic [15:0] m_delay;
  logic [15:0] m_half;
  logic        m_open;
  logic        m_stop;
  logic        m_read;
  logic        m_nack;
  logic        m_arb;
  logic        m_scl_low;
  logic        m_sda_low;
  logic [7:0]  m_rx;
  logic        m_ack;

  out_item_t   expected_results[$];
  out_item_t   want_res;
  int          errors;
  int          result_no;
  int          idle_cycles;
  int          out_hold;
  bit          out_took;
  bit          calm;
  int          stretch_left;
  logic        slave_sda;

  i2c_master_byte_controller u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit half_elapsed();
    if (m_delay >= m_half) return 1'b1;
    m_delay = m_delay + 16'd1;
    return 1'b0;
  endfunction

  function automatic logic sda_released();
    if (m_bits < BYTE_BITS) return m_read ? 1'b1 : m_shift[7];
    return m_read ? m_nack : 1'b1;
  endfunction

  function automatic void goto_phase(input seq_phase_e p);
    m_phase = p;
    m_delay = 16'd0;
  endfunction

  function automatic void setup_next_bit();
    goto_phase(S_BIT_SETUP);
    m_sda_low = !sda_released();
  endfunction

  function automatic out_item_t bus_tick(input in_item_t it);
    out_item_t res;
    bit done;
    logic rd;
    logic master_drives;
    done = 1'b0;
    rd = m_read;
    case (m_phase)
      S_RESTART_SETUP: begin
        if (half_elapsed()) begin
          m_scl_low = 1'b0;
          goto_phase(S_START_WAIT);
        end
      end
      S_START_WAIT: begin
        if (it.scl_in) begin
          if (!it.sda_in) m_arb = 1'b1;
          m_sda_low = 1'b1;
          goto_phase(S_START_HOLD);
        end
      end
      S_START_HOLD: begin
        if (half_elapsed()) begin
          m_scl_low = 1'b1;
          m_open = 1'b1;
          setup_next_bit();
        end
      end
      S_BIT_SETUP: begin
        if (half_elapsed()) begin
          m_scl_low = 1'b0;
          goto_phase(S_BIT_WAIT);
        end
      end
      S_BIT_WAIT: begin
        if (it.scl_in) begin
          master_drives = rd ? (m_bits >= BYTE_BITS) : (m_bits < BYTE_BITS);
          if (master_drives) begin
            if (sda_released() && !it.sda_in) m_arb = 1'b1;
          end else if (m_bits < BYTE_BITS) begin
            m_shift = {m_shift[6:0], it.sda_in};
          end else begin
            m_ack = it.sda_in;
          end
          goto_phase(S_BIT_HOLD);
        end
      end
      S_BIT_HOLD: begin
        if (half_elapsed()) begin
          m_scl_low = 1'b1;
          if (!rd && m_bits < BYTE_BITS) m_shift = {m_shift[6:0], 1'b0};
          m_bits = m_bits + 4'd1;
          if (m_bits <= BYTE_BITS) begin
            setup_next_bit();
          end else if (m_stop) begin
            m_sda_low = 1'b1;
            goto_phase(S_STOP_SETUP);
          end else begin
            done = 1'b1;
          end
        end
      end
      S_STOP_SETUP: begin
        if (half_elapsed()) begin
          m_scl_low = 1'b0;
          goto_phase(S_STOP_WAIT);
        end
      end
      S_STOP_WAIT: begin
        if (it.scl_in) begin
          m_sda_low = 1'b0;
          goto_phase(S_STOP_HOLD);
        end
      end
      S_STOP_HOLD: begin
        if (m_delay == 16'd0 && !it.sda_in) m_arb = 1'b1;
        if (half_elapsed()) begin
          m_open = 1'b0;
          done = 1'b1;
        end
      end
      default: begin
        m_phase = S_IDLE;
        if (it.func == CMD_WRITE || it.func == CMD_READ) begin
          m_stop = it.stop_req;
          m_read = (it.func == CMD_READ);
          m_nack = it.ack_to_send;
          m_arb = 1'b0;
          m_shift = (it.func == CMD_WRITE) ? it.tx_byte : 8'h00;
          m_bits = 4'd0;
          m_delay = 16'd0;
          if (it.start_req) begin
            m_sda_low = 1'b0;
            if (m_open) begin
              goto_phase(S_RESTART_SETUP);
            end else begin
              m_scl_low = 1'b0;
              goto_phase(S_START_WAIT);
            end
          end else begin
            setup_next_bit();
          end
        end
      end
    endcase
    if (done) begin
      if (rd) m_rx = m_shift;
      goto_phase(S_IDLE);
    end
    res.scl_drive_low = m_scl_low;
    res.sda_drive_low = m_sda_low;
    res.ready_res = (m_phase == S_IDLE);
    res.done_res = done;
    res.rx_byte = m_rx;
    res.ack_received = m_ack;
    res.arb_lost = m_arb;
    return res;
  endfunction

  function automatic in_item_t make_tick();
    in_item_t it;
    int pick;
    it.func = cmd_t'($urandom_range(0, 3));
    it.start_req = 1'($urandom_range(0, 1));
    it.stop_req = 1'($urandom_range(0, 1));
    it.tx_byte = 8'($urandom_range(0, 255));
    it.ack_to_send = 1'($urandom_range(0, 1));
    if (m_phase == S_IDLE) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) it.func = CMD_NONE;
      else if (pick == 1) it.func = CMD_UNUSED;
      else it.func = pick[0] ? CMD_WRITE : CMD_READ;
      it.start_req = m_open ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 3) != 0);
      it.stop_req = ($urandom_range(0, 2) == 0);
    end
    if (stretch_left == 0 && $urandom_range(0, 15) == 0) stretch_left = $urandom_range(1, 6);
    if ($urandom_range(0, 3) == 0) slave_sda = !slave_sda;
    it.scl_in = !m_scl_low && stretch_left == 0;
    it.sda_in = !m_sda_low && slave_sda;
    if (stretch_left > 0) stretch_left--;
    if ($urandom_range(0, 19) == 0) begin
      it.scl_in = 1'($urandom_range(0, 1));
      it.sda_in = 1'($urandom_range(0, 1));
    end
    return it;
  endfunction

  function automatic cmd_row_t mk_row(input cmd_t f, input logic st, input logic sp,
                                      input logic [7:0] tx, input logic ack,
                                      input logic slave, input bit typed,
                                      input out_item_t want);
    cmd_row_t row;
    row.cmd.func = f;
    row.cmd.start_req = st;
    row.cmd.stop_req = sp;
    row.cmd.tx_byte = tx;
    row.cmd.ack_to_send = ack;
    row.cmd.scl_in = 1'b1;
    row.cmd.sda_in = 1'b1;
    row.slave_sda = slave;
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  task automatic send_tick(input in_item_t it, input bit typed, input out_item_t want);
    int gap;
    out_item_t predicted;
    gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    predicted = bus_tick(it);
    expected_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic set_half(input logic [15:0] v);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    m_half = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int count, input bit no_idle);
    calm = no_idle;
    repeat (count) send_tick(make_tick(), 1'b0, '0);
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    errors++;
    $display("result %0d: %s got 'h%0h expected 'h%0h", result_no, what, got, want);
  endtask

  always @(negedge clk) begin
    if (out_took) out_hold = calm ? 0 : $urandom_range(0, MAX_WAIT);
    if (out_hold > 0) begin
      out_hold = out_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_took = rst_n && out_valid && out_ready;
    if (out_took) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 16'(out_item), 16'd0);
      end else begin
        want_res = expected_results.pop_front();
        if (out_item.scl_drive_low !== want_res.scl_drive_low)
          report_mismatch("scl_drive_low", 16'(out_item.scl_drive_low),
                          16'(want_res.scl_drive_low));
        if (out_item.sda_drive_low !== want_res.sda_drive_low)
          report_mismatch("sda_drive_low", 16'(out_item.sda_drive_low),
                          16'(want_res.sda_drive_low));
        if (out_item.ready_res !== want_res.ready_res)
          report_mismatch("ready_res", 16'(out_item.ready_res), 16'(want_res.ready_res));
        if (out_item.done_res !== want_res.done_res)
          report_mismatch("done_res", 16'(out_item.done_res), 16'(want_res.done_res));
        if (out_item.rx_byte !== want_res.rx_byte)
          report_mismatch("rx_byte", 16'(out_item.rx_byte), 16'(want_res.rx_byte));
        if (out_item.ack_received !== want_res.ack_received)
          report_mismatch("ack_received", 16'(out_item.ack_received),
                          16'(want_res.ack_received));
        if (out_item.arb_lost !== want_res.arb_lost)
          report_mismatch("arb_lost", 16'(out_item.arb_lost),
                          16'(want_res.arb_lost));
      end
      result_no++;
    end
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    cmd_row_t  rows [0:9];
    out_item_t res_idle;
    out_item_t res_busy;
    in_item_t  it;
    int        n;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 16'd0;
    errors = 0;
    result_no = 0;
    idle_cycles = 0;
    out_hold = 0;
    out_took = 1'b0;
    calm = 1'b0;
    stretch_left = 0;
    slave_sda = 1'b1;

    m_phase = S_IDLE;
    m_bits = 4'd0;
    m_shift = 8'h00;
    m_delay = 16'd0;
    m_half = 16'd0;
    m_open = 1'b0;
    m_stop = 1'b0;
    m_read = 1'b0;
    m_nack = 1'b0;
    m_arb = 1'b0;
    m_scl_low = 1'b0;
    m_sda_low = 1'b0;
    m_rx = 8'h00;
    m_ack = 1'b0;

    res_idle = '0;
    res_idle.ready_res = 1'b1;
    res_busy = '0;

    rows[0] = mk_row(CMD_NONE,   1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, res_idle);
    rows[1] = mk_row(CMD_UNUSED, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b1, res_idle);
    rows[2] = mk_row(CMD_WRITE,  1'b1, 1'b0, 8'hFF, 1'b0, 1'b1, 1'b1, res_busy);
    rows[3] = mk_row(CMD_WRITE,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, '0);
    rows[4] = mk_row(CMD_READ,   1'b1, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, '0);
    rows[5] = mk_row(CMD_READ,   1'b0, 1'b1, 8'h00, 1'b1, 1'b0, 1'b0, '0);
    rows[6] = mk_row(CMD_WRITE,  1'b0, 1'b1, 8'h5A, 1'b0, 1'b0, 1'b0, '0);
    rows[7] = mk_row(CMD_WRITE,  1'b1, 1'b1, 8'hA5, 1'b1, 1'b1, 1'b0, '0);
    rows[8] = mk_row(CMD_WRITE,  1'b1, 1'b0, 8'h80, 1'b0, 1'b0, 1'b0, '0);
    rows[9] = mk_row(CMD_READ,   1'b1, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b0, '0);

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Each row issues its command, then follows the bus until idle or until ROW_TICK_CAP ticks.
    foreach (rows[r]) begin
      n = 0;
      do begin
        it = rows[r].cmd;
        it.scl_in = !m_scl_low;
        it.sda_in = !m_sda_low && rows[r].slave_sda;
        send_tick(it, rows[r].typed && n == 0, rows[r].want);
        n++;
      end while (m_phase != S_IDLE && n < ROW_TICK_CAP);
    end

    set_half(16'd1);
    run_random(400, 1'b0);
    set_half(16'hFFFF);
    run_random(150, 1'b0);
    set_half(16'd0);
    run_random(500, 1'b1);
    set_half(16'($urandom_range(2, 6)));
    run_random(450, 1'b0);
    set_half(16'd1);
    run_random(500, 1'b0);

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
